// File: design/wdda_pkg.sv
// Shared types and constants for the working-day date advance block.
// Used by wdda_seq, wdda_datapath and the top level; no dependencies.
`default_nettype none

package wdda_pkg;

  localparam logic [13:0] LAST_YEAR = 14'd9999;
  localparam int unsigned CNT_LIMIT = 4095;  // largest count the 12-bit field can carry
  // Reciprocal constants: x/100 = (x*5243)>>19, x/7 = (x*18725)>>17 (exact for x < 43690)
  localparam logic [14:0] RECIP_100 = 15'd5243;
  localparam logic [14:0] RECIP_7   = 15'd18725;

  typedef logic [2:0] step_t;

  localparam step_t STEP_IDLE  = 3'd0;
  localparam step_t STEP_MULY  = 3'd1;
  localparam step_t STEP_YRINI = 3'd2;
  localparam step_t STEP_CHECK = 3'd3;
  localparam step_t STEP_MUL7  = 3'd4;
  localparam step_t STEP_MOD7  = 3'd5;
  localparam step_t STEP_WALK  = 3'd6;
  localparam step_t STEP_DONE  = 3'd7;

  typedef enum logic [1:0] {
    MUL_YEAR,
    MUL_YY,
    MUL_WSUM
  } mul_sel_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_START,
    COND_BAD,
    COND_WALKING,
    COND_ALWAYS
  } cond_e;

  typedef struct packed {
    mul_sel_e mul_sel;
    logic     ld_q;
    logic     yr_init;
    logic     check;
    logic     ld_w;
    logic     walk;
    logic     emit;
    cond_e    cond;
    step_t    target;
  } ctl_t;

  typedef struct packed {
    logic bad;
    logic walk_end;
  } status_t;

  typedef struct packed {
    logic [4:0]  start_day;
    logic [3:0]  start_month;
    logic [13:0] start_year;
    logic [11:0] working_day_count;
  } cmd_t;

  typedef struct packed {
    logic [4:0]  return_day;
    logic [3:0]  return_month;
    logic [13:0] return_year;
    logic        bad_date;
  } result_t;

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    begin
      case (m)
        4'd2:    len = leap ? 5'd29 : 5'd28;
        4'd4:    len = 5'd30;
        4'd6:    len = 5'd30;
        4'd9:    len = 5'd30;
        4'd11:   len = 5'd30;
        default: len = 5'd31;
      endcase
      return len;
    end
  endfunction

  // (31*mm)/12 term of the weekday formula, mm counted from March
  function automatic logic [4:0] month_offset(input logic [3:0] m);
    logic [4:0] off;
    begin
      case (m)
        4'd1:    off = 5'd28;
        4'd2:    off = 5'd31;
        4'd3:    off = 5'd2;
        4'd4:    off = 5'd5;
        4'd5:    off = 5'd7;
        4'd6:    off = 5'd10;
        4'd7:    off = 5'd12;
        4'd8:    off = 5'd15;
        4'd9:    off = 5'd18;
        4'd10:   off = 5'd20;
        4'd11:   off = 5'd23;
        4'd12:   off = 5'd25;
        default: off = 5'd0;
      endcase
      return off;
    end
  endfunction

endpackage

`default_nettype wire

// File: design/wdda_seq.sv
// Microcode sequencer: step counter, control-word ROM and conditional jumps.
// Depends on wdda_pkg.
`default_nettype none

module wdda_seq import wdda_pkg::*; (
  input  wire     clk_i,
  input  wire     rst_ni,
  input  wire     start_i,
  input  status_t status_i,
  output ctl_t    ctl_o,
  output logic    busy_o
);

  function automatic ctl_t ucode(input step_t s);
    ctl_t w;
    begin
      w = '{mul_sel: MUL_YEAR, ld_q: 1'b0, yr_init: 1'b0, check: 1'b0, ld_w: 1'b0,
            walk: 1'b0, emit: 1'b0, cond: COND_NEVER, target: STEP_IDLE};
      case (s)
        STEP_IDLE: begin
          w.cond   = COND_NO_START;
          w.target = STEP_IDLE;
        end
        STEP_MULY: begin
          w.mul_sel = MUL_YEAR;
          w.ld_q    = 1'b1;
        end
        STEP_YRINI: begin
          w.yr_init = 1'b1;
          w.mul_sel = MUL_YY;
          w.ld_q    = 1'b1;
        end
        STEP_CHECK: begin
          w.check  = 1'b1;
          w.cond   = COND_BAD;
          w.target = STEP_DONE;
        end
        STEP_MUL7: begin
          w.mul_sel = MUL_WSUM;
          w.ld_q    = 1'b1;
        end
        STEP_MOD7: begin
          w.ld_w = 1'b1;
        end
        STEP_WALK: begin
          w.walk   = 1'b1;
          w.cond   = COND_WALKING;
          w.target = STEP_WALK;
        end
        STEP_DONE: begin
          w.emit   = 1'b1;
          w.cond   = COND_ALWAYS;
          w.target = STEP_IDLE;
        end
        default: w.cond = COND_ALWAYS;
      endcase
      return w;
    end
  endfunction

  step_t pc_q, pc_d;
  logic  taken;

  assign ctl_o  = ucode(pc_q);
  assign busy_o = (pc_q != STEP_IDLE);

  always_comb begin
    case (ctl_o.cond)
      COND_NO_START: taken = !start_i;
      COND_BAD:      taken = status_i.bad;
      COND_WALKING:  taken = !status_i.walk_end;
      COND_ALWAYS:   taken = 1'b1;
      default:       taken = 1'b0;
    endcase
    pc_d = taken ? ctl_o.target : pc_q + 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

// File: design/wdda_datapath.sv
// Datapath: date registers, shared reciprocal multiplier, year residues,
// weekday tracker and working-day counter. Depends on wdda_pkg.
`default_nettype none

module wdda_datapath import wdda_pkg::*; #(
  parameter int unsigned MAX_WORKING_DAYS = 4095
) (
  input  wire        clk_i,
  input  wire        load_i,
  input  cmd_t       cmd_i,
  input  ctl_t       ctl_i,
  input  wire  [2:0] wkend_first_i,
  input  wire  [2:0] wkend_second_i,
  output status_t    status_o,
  output result_t    result_o
);

  localparam int unsigned NCap = (MAX_WORKING_DAYS > CNT_LIMIT) ? CNT_LIMIT : MAX_WORKING_DAYS;
  localparam logic [11:0] NCapV = NCap[11:0];

  logic [4:0]  d_q;
  logic [3:0]  m_q;
  logic [13:0] y_q;
  logic [11:0] n_q;
  logic [12:0] cnt_q;
  logic        bad_q;
  logic [11:0] q_q;
  logic [14:0] wsum_q;
  logic [2:0]  w_q;
  logic [1:0]  r4_q;    // year mod 4
  logic [6:0]  r100_q;  // year mod 100
  logic [1:0]  q4_q;    // (year / 100) mod 4

  logic        leap, eom, ovf, work, invalid;
  logic [4:0]  dim;
  logic [13:0] yy;
  logic [14:0] mul_a, mul_c, wsum;
  logic [29:0] prod;
  logic [11:0] mul_q;
  logic [12:0] cnt_next;
  logic [11:0] n_sat;

  assign leap = ((r4_q == 2'd0) && (r100_q != 7'd0)) || ((r100_q == 7'd0) && (q4_q == 2'd0));
  assign dim  = month_days(m_q, leap);
  assign yy   = (m_q <= 4'd2) ? y_q - 14'd1 : y_q;

  assign invalid = (m_q == 4'd0) || (m_q > 4'd12) || (y_q == 14'd0) || (y_q > LAST_YEAR)
                 || (d_q == 5'd0) || (d_q > dim);

  always_comb begin
    case (ctl_i.mul_sel)
      MUL_YY:   mul_a = {1'b0, yy};
      MUL_WSUM: mul_a = wsum_q;
      default:  mul_a = {1'b0, y_q};
    endcase
    mul_c = (ctl_i.mul_sel == MUL_WSUM) ? RECIP_7 : RECIP_100;
    prod  = 30'(mul_a) * 30'(mul_c);
    mul_q = (ctl_i.mul_sel == MUL_WSUM) ? prod[28:17] : {4'd0, prod[26:19]};
  end

  // q_q holds yy/100 here
  assign wsum = 15'(d_q) + 15'(yy) + 15'(yy >> 2) - 15'(q_q[7:0]) + 15'(q_q[7:2])
              + 15'(month_offset(m_q));

  assign work     = (w_q != wkend_first_i) && (w_q != wkend_second_i);
  assign cnt_next = cnt_q + 13'(work);
  assign eom      = (d_q == dim);
  assign ovf      = eom && (m_q == 4'd12) && (y_q == LAST_YEAR);

  assign n_sat = (cmd_i.working_day_count > NCapV) ? NCapV : cmd_i.working_day_count;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      d_q   <= cmd_i.start_day;
      m_q   <= cmd_i.start_month;
      y_q   <= cmd_i.start_year;
      n_q   <= n_sat;
      cnt_q <= '0;
      bad_q <= 1'b0;
    end
    if (ctl_i.ld_q) begin
      q_q <= mul_q;
    end
    if (ctl_i.yr_init) begin
      r4_q   <= y_q[1:0];
      r100_q <= 7'(y_q - 14'(q_q[7:0]) * 14'd100);
      q4_q   <= q_q[1:0];
    end
    if (ctl_i.check) begin
      bad_q  <= invalid;
      wsum_q <= wsum;
    end
    if (ctl_i.ld_w) begin
      w_q <= 3'(wsum_q - 15'(q_q) * 15'd7);
    end
    if (ctl_i.walk) begin
      cnt_q <= cnt_next;
      w_q   <= (w_q == 3'd6) ? 3'd0 : w_q + 3'd1;
      if (ovf) begin
        bad_q <= 1'b1;  // date stays on the last day of the range
      end else if (eom) begin
        d_q <= 5'd1;
        if (m_q == 4'd12) begin
          m_q  <= 4'd1;
          y_q  <= y_q + 14'd1;
          r4_q <= r4_q + 2'd1;
          if (r100_q == 7'd99) begin
            r100_q <= 7'd0;
            q4_q   <= q4_q + 2'd1;
          end else begin
            r100_q <= r100_q + 7'd1;
          end
        end else begin
          m_q <= m_q + 4'd1;
        end
      end else begin
        d_q <= d_q + 5'd1;
      end
    end
  end

  assign status_o.bad      = invalid;
  assign status_o.walk_end = ovf || (cnt_next > {1'b0, n_q});

  assign result_o.return_day   = d_q;
  assign result_o.return_month = m_q;
  assign result_o.return_year  = y_q;
  assign result_o.bad_date     = bad_q;

endmodule

`default_nettype wire

// File: design/working_day_date_advance.sv
// Top level of the working-day date advance block: APB register file,
// microcode sequencer and datapath. Depends on wdda_pkg, wdda_seq, wdda_datapath.
//
// An item is taken when start_i is high while busy_o is low; its result shows on
// result_o for one cycle with done_o high and cannot be held off. A valid date
// keeps the block busy through the steps MULY, YRINI, CHECK, MUL7 and MOD7, then
// a WALK step for each calendar day walked (about 1.4*(N+1) days), then DONE; the walk
// loop advances one day per cycle. An invalid start date goes from CHECK straight
// to DONE. N is clamped to MAX_WORKING_DAYS. Weekend days live at APB offsets 0x0
// and 0x4 (reset Friday and Saturday); write them only while the block is idle.
`default_nettype none

module working_day_date_advance import wdda_pkg::*; #(
  parameter int unsigned MAX_WORKING_DAYS = 4095
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          start_i,
  input  cmd_t         cmd_i,
  output logic         busy_o,
  output logic         done_o,
  output result_t      result_o,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire   [2:0]  paddr,
  input  wire   [31:0] pwdata,
  output logic  [31:0] prdata,
  output logic         pready
);

  logic [2:0] wk1_q, wk2_q;
  ctl_t       ctl;
  status_t    status;
  logic       accept;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {29'd0, wk2_q} : {29'd0, wk1_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wk1_q <= 3'd5;
      wk2_q <= 3'd6;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        wk2_q <= pwdata[2:0];
      end else begin
        wk1_q <= pwdata[2:0];
      end
    end
  end

  assign accept = start_i && !busy_o;
  assign done_o = ctl.emit;

  wdda_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .ctl_o    (ctl),
    .busy_o   (busy_o)
  );

  wdda_datapath #(
    .MAX_WORKING_DAYS (MAX_WORKING_DAYS)
  ) u_datapath (
    .clk_i          (clk_i),
    .load_i         (accept),
    .cmd_i          (cmd_i),
    .ctl_i          (ctl),
    .wkend_first_i  (wk1_q),
    .wkend_second_i (wk2_q),
    .status_o       (status),
    .result_o       (result_o)
  );

endmodule

`default_nettype wire

// File: tb/wdda_checker.sv
// Checker for working_day_date_advance: tracks APB writes to the weekend registers,
// checks reads of them, predicts each return date and compares it with the result items.
// Depends on wdda_pkg (cmd_t, result_t).
`default_nettype none

module wdda_checker import wdda_pkg::*; #(
  parameter logic [2:0]  FIRST_ADDR  = 3'd0,
  parameter logic [2:0]  SECOND_ADDR = 3'd4,
  parameter int unsigned COUNT_CAP   = 4095
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  input  cmd_t        cmd_i,
  input  wire         busy_i,
  input  wire         done_i,
  input  result_t     result_i,
  input  wire         psel_i,
  input  wire         penable_i,
  input  wire         pwrite_i,
  input  wire  [2:0]  paddr_i,
  input  wire  [31:0] pwdata_i,
  input  wire  [31:0] prdata_i,
  input  wire         pready_i,
  output int          fail_count_o,
  output int          open_items_o,
  output int          dates_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [2:0] off_day_a = 3'd5;
  logic [2:0] off_day_b = 3'd6;
  result_t    return_dates_due[$];
  int         failures = 0;
  int         checked = 0;

  function automatic bit leap_year(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int days_of_month(int m, int y);
    case (m)
      2:             return leap_year(y) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  // Zeller's congruence, shifted so that 0 is Sunday
  function automatic int weekday_of(int d, int m, int y);
    int mz, yz, k, j, h;
    mz = (m < 3) ? m + 12 : m;
    yz = (m < 3) ? y - 1 : y;
    k  = yz % 100;
    j  = yz / 100;
    h  = (d + (13 * (mz + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
    return (h + 6) % 7;
  endfunction

  function automatic result_t project_return(cmd_t c, logic [2:0] off_a, logic [2:0] off_b);
    result_t r;
    int d, m, y, n, tally, wd;
    bit ovf;
    d = int'(c.start_day);
    m = int'(c.start_month);
    y = int'(c.start_year);
    n = int'(c.working_day_count);
    if (n > int'(COUNT_CAP)) n = int'(COUNT_CAP);
    ovf = 1'b0;
    if (m < 1 || m > 12 || y < 1 || y > 9999 || d < 1 || d > days_of_month(m, y)) begin
      ovf = 1'b1;  // invalid start: date echoed
    end else begin
      wd = weekday_of(d, m, y);
      tally = 0;
      // the day after the (N+1)-th working day; a weekend value of 7 never matches
      while (tally <= n && !ovf) begin
        if (wd != int'(off_a) && wd != int'(off_b)) tally++;
        if (d == days_of_month(m, y)) begin
          if (m == 12 && y == 9999) begin
            ovf = 1'b1;  // stuck on the last representable day
          end else if (m == 12) begin
            d = 1;
            m = 1;
            y++;
          end else begin
            d = 1;
            m++;
          end
        end else begin
          d++;
        end
        wd = (wd + 1) % 7;
      end
    end
    r.return_day   = d[4:0];
    r.return_month = m[3:0];
    r.return_year  = y[13:0];
    r.bad_date     = ovf;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t    want;
    logic [31:0] rd_want;
    if (!rst_ni) begin
      off_day_a <= 3'd5;
      off_day_b <= 3'd6;
      return_dates_due.delete();
    end else begin
      if (done_i) begin
        if (return_dates_due.size() == 0) begin
          failures++;
          $display("%0t ns: result item with none expected: got %0d/%0d/%0d bad=%0b", $time,
                   result_i.return_day, result_i.return_month, result_i.return_year,
                   result_i.bad_date);
        end else begin
          want = return_dates_due.pop_front();
          checked++;
          if (result_i.return_day !== want.return_day
              || result_i.return_month !== want.return_month
              || result_i.return_year !== want.return_year
              || result_i.bad_date !== want.bad_date) begin
            failures++;
            $display("%0t ns: mismatch: expected %0d/%0d/%0d bad=%0b, got %0d/%0d/%0d bad=%0b",
                     $time, want.return_day, want.return_month, want.return_year,
                     want.bad_date, result_i.return_day, result_i.return_month,
                     result_i.return_year, result_i.bad_date);
          end
        end
      end
      if (start_i && !busy_i)
        return_dates_due.push_back(project_return(cmd_i, off_day_a, off_day_b));
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          case (paddr_i)
            FIRST_ADDR:  off_day_a <= pwdata_i[2:0];
            SECOND_ADDR: off_day_b <= pwdata_i[2:0];
            default: ;
          endcase
        end else begin
          rd_want = (paddr_i == FIRST_ADDR) ? {29'd0, off_day_a} : {29'd0, off_day_b};
          if (prdata_i !== rd_want) begin
            failures++;
            $display("%0t ns: register read at 0x%0h: expected 0x%0h, got 0x%0h", $time,
                     paddr_i, rd_want, prdata_i);
          end
        end
      end
    end
    fail_count_o    <= failures;
    open_items_o    <= return_dates_due.size();
    dates_checked_o <= checked;
  end

endmodule

`default_nettype wire

// File: tb/tb.sv
// Top of the working_day_date_advance testbench: clock, reset, APB and command stimulus.
// Checking lives in wdda_checker; depends on wdda_pkg and the block itself.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wdda_pkg::*;

  localparam logic [2:0] OFF_FIRST_ADDR  = 3'd0;
  localparam logic [2:0] OFF_SECOND_ADDR = 3'd4;
  localparam int         CYCLE_LIMIT     = 4000000;
  localparam int         RANDOM_ITEMS    = 64;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  cmd_t        cmd_i = '0;
  logic        busy_o, done_o;
  result_t     result_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, open_items, dates_checked;
  int          cycles = 0;
  int          items_sent = 0;
  int          settings_used = 1;

  working_day_date_advance i_dut (
    .clk_i, .rst_ni, .start_i, .cmd_i, .busy_o, .done_o, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  wdda_checker #(
    .FIRST_ADDR (OFF_FIRST_ADDR),
    .SECOND_ADDR(OFF_SECOND_ADDR)
  ) i_checker (
    .clk_i, .rst_ni, .start_i, .cmd_i, .busy_i(busy_o), .done_i(done_o),
    .result_i(result_o), .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite),
    .paddr_i(paddr), .pwdata_i(pwdata), .prdata_i(prdata), .pready_i(pready),
    .fail_count_o(fail_count), .open_items_o(open_items), .dates_checked_o(dates_checked)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items still open", cycles, open_items);
      $display("TB_ERROR");
      $finish;
    end
  end

  // all tasks are entered and left just after a rising edge
  task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [2:0] val);
    logic [31:0] junk;
    junk = $urandom;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= {junk[31:3], val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (open_items != 0 || busy_o);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_weekend(input logic [2:0] a, input logic [2:0] b);
    wait_idle();
    apb_xfer(1'b1, OFF_FIRST_ADDR, a);
    apb_xfer(1'b1, OFF_SECOND_ADDR, b);
    apb_xfer(1'b0, OFF_FIRST_ADDR, '0);
    apb_xfer(1'b0, OFF_SECOND_ADDR, '0);
    settings_used++;
  endtask

  task automatic send(input cmd_t c);
    int pick, gap;
    start_i <= 1'b1;
    cmd_i   <= c;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
    pick = $urandom_range(0, 99);
    gap  = (pick < 55) ? 0 : (pick < 90) ? $urandom_range(1, 3) : $urandom_range(20, 200);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic cmd_t mk(int d, int m, int y, int n);
    cmd_t c;
    c.start_day         = d[4:0];
    c.start_month       = m[3:0];
    c.start_year        = y[13:0];
    c.working_day_count = n[11:0];
    return c;
  endfunction

  // mostly well-formed dates with small counts; some raw fields, some in years 9990 to 9999
  function automatic cmd_t random_cmd();
    cmd_t c;
    int r, q, y, n;
    r = $urandom_range(0, 99);
    q = $urandom_range(0, 99);
    n = (q < 80) ? $urandom_range(0, 40) : (q < 96) ? $urandom_range(0, 4095) : 4095;
    if (r < 12) begin
      c = cmd_t'($urandom);
      c.working_day_count = n[11:0];
    end else begin
      y = (r < 22) ? $urandom_range(9990, 9999) : $urandom_range(1, 9999);
      c = mk(($urandom_range(0, 99) < 85) ? $urandom_range(1, 28) : $urandom_range(29, 31),
             $urandom_range(1, 12), y, n);
    end
    return c;
  endfunction

  initial begin
    logic [2:0] wk_a, wk_b;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset weekend values read back, then directed dates on Friday/Saturday weekends
    apb_xfer(1'b0, OFF_FIRST_ADDR, '0);
    apb_xfer(1'b0, OFF_SECOND_ADDR, '0);
    send(mk(1, 1, 1, 0));
    send(mk(31, 12, 9999, 0));       // walk would pass the last day
    send(mk(20, 12, 9999, 30));
    send(mk(29, 2, 2000, 5));        // leap day, divisible by 400
    send(mk(29, 2, 1900, 3));        // no leap day in a century year
    send(mk(28, 2, 2024, 1));
    send(mk(0, 5, 2020, 2));
    send(mk(31, 4, 2021, 2));
    send(mk(31, 2, 2020, 0));
    send(mk(15, 0, 2021, 1));
    send(mk(15, 13, 2021, 1));
    send(mk(31, 15, 16383, 4095));
    send(mk(10, 6, 0, 7));
    send(mk(10, 6, 10000, 7));
    send(mk(1, 3, 2023, 4095));
    send(mk(31, 1, 2023, 0));
    send(mk(31, 12, 2022, 2));
    send(mk(30, 11, 9999, 2000));

    // weekend extremes: same day twice, value seven, wrap of Saturday/Sunday
    set_weekend(3'd0, 3'd0);
    repeat (4) send(random_cmd());
    set_weekend(3'd7, 3'd7);
    send(mk(1, 1, 2024, 4095));
    repeat (3) send(random_cmd());
    set_weekend(3'd6, 3'd0);
    repeat (4) send(random_cmd());
    set_weekend(3'd3, 3'd3);
    repeat (4) send(random_cmd());
    set_weekend(3'd7, 3'd1);
    repeat (4) send(random_cmd());
    set_weekend(3'd2, 3'd5);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 25 == 24) begin
        wk_a = 3'($urandom_range(0, 7));
        wk_b = 3'($urandom_range(0, 7));
        set_weekend(wk_a, wk_b);
      end else if (i == 60) begin
        wait_idle();  // let the block drain with no configuration change
      end
      send(random_cmd());
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    $display("Sent %0d dates (%0d checked) over %0d weekend settings,", items_sent,
             dates_checked, settings_used);
    $display("including invalid dates, leap days, count extremes and year 9999 overflow.");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
design/wdda_pkg.sv
design/wdda_seq.sv
design/wdda_datapath.sv
design/working_day_date_advance.sv
tb/wdda_checker.sv
tb/tb.sv
